[src/sacc_pkg.sv]
// Package for the set-associative cache controller: sizes, line and row types,
// configuration indexes, controller states and the lookup result struct.
// No dependencies.
package sacc_pkg;

  localparam int unsigned Sets      = 256;
  localparam int unsigned Ways      = 4;
  localparam int unsigned SetW      = $clog2(Sets);
  localparam int unsigned WayW      = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned TagW      = 30;
  localparam int unsigned StampW    = 32;
  localparam int unsigned CyclesW   = 18;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 4;
  localparam int unsigned MaxIdxBits = SetW;

  // Cost constants
  localparam logic [CyclesW-1:0] WordCost = CyclesW'(100);
  localparam logic [CyclesW-1:0] HitCost  = CyclesW'(1);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_INDEX_BITS  = 3'd0,
    CFG_OFFSET_BITS = 3'd1,
    CFG_WAYS        = 3'd2,
    CFG_WALLOC      = 3'd3,
    CFG_WTHROUGH    = 3'd4,
    CFG_LRU         = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_CMP  = 1'b1
  } state_e;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [TagW-1:0]   tag;
    logic [StampW-1:0] stamp;
  } line_t;

  typedef line_t [Ways-1:0] row_t;

  typedef struct packed {
    logic            hit;
    logic [WayW-1:0] hit_way;
    logic            free;
    logic [WayW-1:0] free_way;
    logic [WayW-1:0] victim_way;
  } lookup_t;

endpackage

[src/sacc_lookup.sv]
// Way search for one set row: hit way, lowest free way and oldest-stamp victim.
// Depends on sacc_pkg.
module sacc_lookup (
  input  sacc_pkg::row_t                 row_i,
  input  logic [sacc_pkg::TagW-1:0]      tag_i,
  input  logic [sacc_pkg::WayW:0]        ways_i,
  output sacc_pkg::lookup_t              res_o
);

  // lowest matching way, lowest invalid way, smallest stamp (lowest on ties)
  always_comb begin
    logic [sacc_pkg::WayW-1:0]   vic;
    res_o = '0;
    vic   = '0;
    for (int w = sacc_pkg::Ways - 1; w >= 0; w--) begin
      if ((sacc_pkg::WayW+1)'(w) < ways_i) begin
        if (row_i[w].valid && row_i[w].tag == tag_i) begin
          res_o.hit     = 1'b1;
          res_o.hit_way = sacc_pkg::WayW'(w);
        end
        if (!row_i[w].valid) begin
          res_o.free     = 1'b1;
          res_o.free_way = sacc_pkg::WayW'(w);
        end
      end
    end
    for (int w = 1; w < sacc_pkg::Ways; w++) begin
      if ((sacc_pkg::WayW+1)'(w) < ways_i && row_i[w].stamp < row_i[vic].stamp) begin
        vic = sacc_pkg::WayW'(w);
      end
    end
    res_o.victim_way = vic;
  end

endmodule

[src/set_assoc_cache_controller.sv]
// Top level of the set-associative cache controller (tag-only).
// Depends on sacc_pkg and sacc_lookup.
//
// Each access is handled one at a time: the set row is read from a synchronous
// row memory on the accepting beat (ST_IDLE), then compared across the ways in
// ST_CMP, where it is written back and the result loaded into the output register
// once that register is free or being drained. The next address beat is only taken
// back in ST_IDLE, so a new access is never accepted before the last one is done.
// Per-row written flags stand in for the all-zero reset, so no clearing pass.
module set_assoc_cache_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // address[31:0]
  input  logic        s_axis_tuser,   // mode (0 load, 1 store)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // hit, allocated, wrote_back, cycles_added[17:0], zero pad
);

  // configuration registers
  logic [3:0] index_bits_q, offset_bits_q;
  logic [2:0] ways_q;
  logic       walloc_q, wthrough_q, lru_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q  <= 4'd0;
      offset_bits_q <= 4'd4;
      ways_q        <= 3'd1;
      walloc_q      <= 1'b1;
      wthrough_q    <= 1'b0;
      lru_q         <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sacc_pkg::CFG_INDEX_BITS:  index_bits_q  <= cfg_wdata_i;
        sacc_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata_i;
        sacc_pkg::CFG_WAYS:        ways_q        <= cfg_wdata_i[2:0];
        sacc_pkg::CFG_WALLOC:      walloc_q      <= cfg_wdata_i[0];
        sacc_pkg::CFG_WTHROUGH:    wthrough_q    <= cfg_wdata_i[0];
        sacc_pkg::CFG_LRU:         lru_q         <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // clamped settings
  logic [3:0] ib, ob;
  logic [sacc_pkg::WayW:0] nw;
  always_comb begin
    ib = (index_bits_q > 4'(sacc_pkg::MaxIdxBits)) ? 4'(sacc_pkg::MaxIdxBits) : index_bits_q;
    ob = (offset_bits_q < 4'd2) ? 4'd2 : ((offset_bits_q > 4'd12) ? 4'd12 : offset_bits_q);
    if (ways_q == 3'd0) nw = (sacc_pkg::WayW+1)'(1);
    else if (32'(ways_q) > sacc_pkg::Ways) nw = (sacc_pkg::WayW+1)'(sacc_pkg::Ways);
    else nw = (sacc_pkg::WayW+1)'(ways_q);
  end

  // control
  sacc_pkg::state_e state_q, state_d;
  logic in_beat, done, out_valid_q;
  logic [23:0] out_data_q, out_data_d;

  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign done    = (state_q == sacc_pkg::ST_CMP) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sacc_pkg::ST_IDLE: if (in_beat) state_d = sacc_pkg::ST_CMP;
      sacc_pkg::ST_CMP:  if (done) state_d = sacc_pkg::ST_IDLE;
      default:           state_d = sacc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == sacc_pkg::ST_IDLE);
  end

  // set index of the incoming beat
  logic [sacc_pkg::SetW-1:0] in_set;
  assign in_set = sacc_pkg::SetW'(s_axis_tdata >> ob)
                & sacc_pkg::SetW'(((sacc_pkg::SetW+1)'(1) << ib) - (sacc_pkg::SetW+1)'(1));

  // row memory and per-row written flags
  sacc_pkg::row_t            mem [sacc_pkg::Sets];
  sacc_pkg::row_t            rdata_q;
  logic [sacc_pkg::Sets-1:0] row_ok_q;
  logic                      rok_q;
  logic [sacc_pkg::SetW-1:0] set_q;
  logic [31:0]               addr_q;
  logic                      store_q;
  logic                      we;
  sacc_pkg::row_t            wrow;

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      rdata_q <= mem[in_set];
      rok_q   <= row_ok_q[in_set];
      set_q   <= in_set;
      addr_q  <= s_axis_tdata;
      store_q <= s_axis_tuser;
    end
    if (we) mem[set_q] <= wrow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_ok_q <= '0;
    end else if (we) begin
      row_ok_q[set_q] <= 1'b1;
    end
  end

  // compare and update
  sacc_pkg::row_t    row;
  logic [sacc_pkg::TagW-1:0] tag;
  sacc_pkg::lookup_t lk;
  logic [31:0] count_q;
  logic [sacc_pkg::CyclesW-1:0] miss_cost, cycles;
  logic [sacc_pkg::WayW-1:0] way;
  logic alloc, wb, mark_dirty;

  assign row = rok_q ? rdata_q : '0;
  assign tag = sacc_pkg::TagW'(addr_q >> (5'(ob) + 5'(ib)));

  sacc_lookup u_lookup (
    .row_i  (row),
    .tag_i  (tag),
    .ways_i (nw),
    .res_o  (lk)
  );

  always_comb begin
    miss_cost  = sacc_pkg::WordCost << (ob - 4'd2);
    mark_dirty = store_q && !wthrough_q;
    alloc      = !lk.hit && (!store_q || walloc_q);
    way        = lk.hit ? lk.hit_way : (lk.free ? lk.free_way : lk.victim_way);
    wb         = alloc && !lk.free && row[way].dirty;
    cycles     = (store_q && wthrough_q) ? sacc_pkg::WordCost : '0;
    if (lk.hit) cycles = cycles + sacc_pkg::HitCost;
    if (alloc)  cycles = cycles + miss_cost;
    if (wb)     cycles = cycles + miss_cost;
    wrow = row;
    if (lk.hit) begin
      if (mark_dirty) wrow[way].dirty = 1'b1;
      if (lru_q)      wrow[way].stamp = count_q;
    end else if (alloc) begin
      wrow[way].valid = 1'b1;
      wrow[way].dirty = mark_dirty;
      wrow[way].tag   = tag;
      wrow[way].stamp = count_q;
    end
    we         = done && (lk.hit || alloc);
    out_data_d = {3'b000, cycles, wb, alloc, lk.hit};
  end

  // state, saturating access counter, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sacc_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done && count_q != '1) count_q <= count_q + 32'd1;
      if (done) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[src/sacc_checker.sv]
// Port-level checker for the set-associative cache controller, with its bind.
// Depends on set_assoc_cache_controller ports only.
module sacc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  // one access at a time: no beat taken right after a beat
  a_no_b2b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input beat taken while access in flight");

  // a hit never fills or writes back
  a_hit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1] && !m_axis_tdata[2])
    else $error("hit reported with fill or write-back");

  // a write-back only comes with a fill
  a_wb_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
    else $error("write-back without fill");

endmodule

bind set_assoc_cache_controller sacc_checker u_sacc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[dv/tb_top.sv]
// Self-checking bench for set_assoc_cache_controller: a tag-only cache predictor,
// a queue-fed stream driver and a result monitor, with random idling on both sides.
// Depends on sacc_pkg and the RTL under src/.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RunLimit = 2000000;
  localparam int unsigned NumLines = sacc_pkg::Sets * sacc_pkg::Ways;

  typedef struct packed {
    logic         mode;
    logic [31:0]  addr;
  } access_t;

  typedef struct packed {
    logic [sacc_pkg::CyclesW-1:0] cycles;
    logic                         wrote_back;
    logic                         allocated;
    logic                         hit;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  set_assoc_cache_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predicted cache state and configuration
  logic [3:0]        cfg_index_bits;
  logic [3:0]        cfg_offset_bits;
  logic [2:0]        cfg_ways;
  logic              cfg_walloc;
  logic              cfg_wthrough;
  logic              cfg_lru;
  logic              tag_valid [NumLines];
  logic              tag_dirty [NumLines];
  logic [sacc_pkg::TagW-1:0]   tag_store [NumLines];
  logic [sacc_pkg::StampW-1:0] age_stamp [NumLines];
  logic [31:0]       access_count;

  access_t  pending_accesses[$];
  outcome_t expected_outcomes[$];
  bit       hold_sender;
  bit       idle_off;
  int       mismatches;
  int unsigned run_cycles = 0;

  access_t  cur_access;
  int       send_gap;
  int       stall_len;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_index_bits();
    return (cfg_index_bits > 8) ? 8 : cfg_index_bits;
  endfunction

  function automatic int unsigned eff_offset_bits();
    if (cfg_offset_bits < 2) return 2;
    if (cfg_offset_bits > 12) return 12;
    return cfg_offset_bits;
  endfunction

  // Tag lookup, fill and victim choice for one access
  function automatic outcome_t predict_access(access_t a);
    int unsigned ib, ob, nw, idx, base, w, way, miss_cost;
    logic [sacc_pkg::TagW-1:0] tag;
    logic [31:0] now;
    bit found;
    outcome_t r;
    ib = eff_index_bits();
    ob = eff_offset_bits();
    nw = (cfg_ways == 0) ? 1 : ((cfg_ways > sacc_pkg::Ways) ? sacc_pkg::Ways : cfg_ways);
    idx = (a.addr >> ob) & ((32'd1 << ib) - 1);
    tag = sacc_pkg::TagW'(a.addr >> (ob + ib));
    base = (idx % sacc_pkg::Sets) * sacc_pkg::Ways;
    miss_cost = 100 << (ob - 2);
    now = access_count;
    r = '0;
    way = 0;
    for (w = 0; w < nw; w++) begin
      if (tag_valid[base+w] && tag_store[base+w] == tag) begin
        r.hit = 1'b1;
        way = w;
        break;
      end
    end
    if (a.mode && cfg_wthrough) r.cycles += 100;
    if (r.hit) begin
      r.cycles += 1;
      if (a.mode && !cfg_wthrough) tag_dirty[base+way] = 1'b1;
      if (cfg_lru) age_stamp[base+way] = now;
    end else if (!a.mode || cfg_walloc) begin
      r.cycles += miss_cost;
      found = 0;
      for (w = 0; w < nw; w++) begin
        if (!tag_valid[base+w]) begin
          way = w;
          found = 1;
          break;
        end
      end
      if (!found) begin
        way = 0;
        for (w = 1; w < nw; w++)
          if (age_stamp[base+w] < age_stamp[base+way]) way = w;
        if (tag_dirty[base+way]) begin
          r.wrote_back = 1'b1;
          r.cycles += miss_cost;
        end
      end
      tag_valid[base+way] = 1'b1;
      tag_store[base+way] = tag;
      age_stamp[base+way] = now;
      tag_dirty[base+way] = a.mode && !cfg_wthrough;
      r.allocated = 1'b1;
    end
    if (access_count != 32'hFFFF_FFFF) access_count++;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int p;
    if (idle_off) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stream driver: one beat per handshake, pulled from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    bit      next_valid;
    access_t next_access;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      send_gap      <= 0;
      cur_access    <= '0;
    end else begin
      next_valid = s_axis_tvalid;
      next_access = cur_access;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_outcomes.insert(expected_outcomes.size(), predict_access(cur_access));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_accesses.size() > 0 && !hold_sender) begin
          next_access = pending_accesses.pop_front();
          next_valid = 1'b1;
          send_gap <= pick_gap();
        end
      end
      cur_access    <= next_access;
      s_axis_tvalid <= next_valid;
      s_axis_tdata  <= next_access.addr;
      s_axis_tuser  <= next_access.mode;
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    outcome_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_len     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = outcome_t'(m_axis_tdata[20:0]);
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat %h", m_axis_tdata);
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want || m_axis_tdata[23:21] !== 3'b000) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: hit %b/%b alloc %b/%b wb %b/%b cycles %0d/%0d",
                       want.hit, got.hit, want.allocated, got.allocated,
                       want.wrote_back, got.wrote_back, want.cycles, got.cycles);
          end
        end
      end
      if (stall_len > 0) begin
        stall_len     <= stall_len - 1;
        m_axis_tready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 3) == 0) begin
        stall_len     <= pick_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    run_cycles++;
    if (run_cycles > RunLimit) begin
      $display("set_assoc_cache_controller regression: fail");
      $finish;
    end
  end

  task automatic write_reg(sacc_pkg::cfg_idx_e idx, logic [3:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      sacc_pkg::CFG_INDEX_BITS:  cfg_index_bits  = val;
      sacc_pkg::CFG_OFFSET_BITS: cfg_offset_bits = val;
      sacc_pkg::CFG_WAYS:        cfg_ways        = val[2:0];
      sacc_pkg::CFG_WALLOC:      cfg_walloc      = val[0];
      sacc_pkg::CFG_WTHROUGH:    cfg_wthrough    = val[0];
      sacc_pkg::CFG_LRU:         cfg_lru         = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [3:0] ib, logic [3:0] ob, logic [3:0] nw,
                            logic wa, logic wt, logic lru);
    write_reg(sacc_pkg::CFG_INDEX_BITS, ib);
    write_reg(sacc_pkg::CFG_OFFSET_BITS, ob);
    write_reg(sacc_pkg::CFG_WAYS, nw);
    write_reg(sacc_pkg::CFG_WALLOC, {3'b0, wa});
    write_reg(sacc_pkg::CFG_WTHROUGH, {3'b0, wt});
    write_reg(sacc_pkg::CFG_LRU, {3'b0, lru});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_accesses.size() > 0 || s_axis_tvalid || expected_outcomes.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void queue_access(logic mode, logic [31:0] addr);
    access_t a;
    a.mode = mode;
    a.addr = addr;
    pending_accesses.insert(pending_accesses.size(), a);
  endfunction

  // Random accesses that mostly collide on a few sets and tags
  task automatic queue_random(int count);
    logic [31:0] tags [6];
    logic [31:0] sets [2];
    int unsigned ib, ob, i;
    logic [31:0] a;
    ib = eff_index_bits();
    ob = eff_offset_bits();
    foreach (tags[i]) tags[i] = $urandom;
    foreach (sets[i]) sets[i] = $urandom;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        a = (tags[$urandom_range(0, 5)] << (ob + ib))
          | ((sets[$urandom_range(0, 1)] & ((32'd1 << ib) - 1)) << ob)
          | ($urandom & ((32'd1 << ob) - 1));
      end else begin
        a = $urandom;
      end
      queue_access($urandom_range(0, 1), a);
    end
  endtask

  // Phase sequencing
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = sacc_pkg::CFG_INDEX_BITS;
    cfg_wdata_i   = '0;
    hold_sender   = 0;
    idle_off      = 0;
    mismatches    = 0;
    cfg_index_bits  = 4'd0;
    cfg_offset_bits = 4'd4;
    cfg_ways        = 3'd1;
    cfg_walloc      = 1'b1;
    cfg_wthrough    = 1'b0;
    cfg_lru         = 1'b1;
    access_count    = '0;
    foreach (tag_valid[i]) begin
      tag_valid[i] = 1'b0;
      tag_dirty[i] = 1'b0;
      tag_store[i] = '0;
      age_stamp[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: one set, one way, write-back, allocate
    queue_access(1'b0, 32'h0000_0000);
    queue_access(1'b0, 32'h0000_000F);
    queue_access(1'b1, 32'h0000_0004);
    queue_access(1'b0, 32'h0000_0010);
    queue_access(1'b1, 32'hFFFF_FFFF);
    queue_access(1'b1, 32'hFFFF_FFF0);
    queue_access(1'b0, 32'h8000_0000);
    queue_access(1'b1, 32'h7FFF_FFFF);
    queue_access(1'b0, 32'h7FFF_FFF3);
    queue_access(1'b0, 32'hAAAA_AAAA);
    queue_access(1'b1, 32'h5555_5555);
    queue_access(1'b0, 32'h5555_5550);
    wait_drained();

    // Write-through, no allocate: store misses leave the cache alone
    set_config(4'd0, 4'd4, 4'd2, 1'b0, 1'b1, 1'b1);
    queue_access(1'b1, 32'h0000_1000);
    queue_access(1'b0, 32'h0000_1000);
    queue_access(1'b1, 32'h0000_1000);
    queue_access(1'b1, 32'h0000_2000);
    queue_random(120);
    wait_drained();

    set_config(4'd2, 4'd2, 4'd4, 1'b1, 1'b0, 1'b1);
    queue_random(130);
    wait_drained();

    // Largest blocks and sets, FIFO
    set_config(4'd8, 4'd12, 4'd4, 1'b1, 1'b0, 1'b0);
    idle_off = 1;
    queue_random(130);
    wait_drained();
    idle_off = 0;

    // Out-of-range register values clamp
    set_config(4'd15, 4'd0, 4'd0, 1'b1, 1'b0, 1'b0);
    queue_random(120);
    wait_drained();

    set_config(4'd3, 4'd15, 4'd7, 1'b0, 1'b0, 1'b1);
    queue_random(120);
    wait_drained();

    // Sender holds off mid-phase until every result is back
    set_config(4'd1, 4'd5, 4'd3, 1'b1, 1'b1, 1'b0);
    queue_random(60);
    while (pending_accesses.size() > 30) @(posedge clk_i);
    hold_sender = 1;
    while (s_axis_tvalid || expected_outcomes.size() > 0) @(posedge clk_i);
    hold_sender = 0;
    wait_drained();

    set_config(4'd0, 4'd2, 4'd4, 1'b1, 1'b0, 1'b1);
    queue_random(250);
    wait_drained();

    if (mismatches == 0) begin
      $display("set_assoc_cache_controller regression: pass");
    end else begin
      $display("set_assoc_cache_controller regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
src/sacc_pkg.sv
src/sacc_lookup.sv
src/set_assoc_cache_controller.sv
src/sacc_checker.sv
dv/tb_top.sv
